// ----- hdl/gated_weighted_moving_average_core_assert.svh -----
// assertion macros shared by the weighted moving average rtl
// no dependencies; every macro expands to one concurrent assertion with a reset guard
`ifndef GATED_WEIGHTED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define GATED_WEIGHTED_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define GWMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GWMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gwma_pkg.sv -----
// package for the gated weighted moving average: widths, window depth,
// divider constants and shared types; no dependencies
`default_nettype none

package gwma_pkg;

    // field widths
    localparam int OFS_W   = 16;
    localparam int POS_W   = 24;
    localparam int COLOR_W = 8;

    // window depth, oldest entry at index 0, weight k+1 for entry k
    localparam int WIN_DEPTH = 5;

    // all lanes run at the widest field width
    localparam int LANE_W = POS_W;

    // sum of weights and the rounding divisor 2*total
    localparam int WT_SUM  = WIN_DEPTH * (WIN_DEPTH + 1) / 2;
    localparam int WT_DIV  = 2 * WT_SUM;

    // signed weighted sum, magnitude numerator 2*|sum|+total
    localparam int SUM_W   = LANE_W + $clog2(WT_SUM) + 1;
    localparam int NUM_W   = SUM_W + 1;

    // reciprocal of the divisor scaled by 2^NUM_W
    localparam int REC_W   = NUM_W - $clog2(WT_DIV) + 1;
    localparam int PROD_W  = NUM_W + REC_W;
    localparam longint unsigned REC_FULL = (64'd1 << NUM_W) / WT_DIV;
    localparam logic [REC_W-1:0] REC = REC_W'(REC_FULL);

    typedef logic signed [LANE_W-1:0] t_lane_word;
    typedef t_lane_word t_lane_win [WIN_DEPTH];

    // stage load enables handed to each arithmetic lane
    typedef struct packed {
        logic en_sum;
        logic en_div;
    } t_stage_en;

endpackage

`default_nettype wire

// ----- hdl/gwma_if.sv -----
// request channel interfaces for detection records and averaged results
// depends on gwma_pkg for field widths
`default_nettype none

interface gwma_in_if;
    import gwma_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [OFS_W-1:0]   offset_x;
    logic signed [OFS_W-1:0]   offset_y;
    logic signed [POS_W-1:0]   position_x;
    logic signed [POS_W-1:0]   position_y;
    logic        [COLOR_W-1:0] color_class;
    logic                      detected;

    modport source (
        output valid, offset_x, offset_y, position_x, position_y, color_class, detected,
        input  ready
    );
    modport sink (
        input  valid, offset_x, offset_y, position_x, position_y, color_class, detected,
        output ready
    );
endinterface

interface gwma_out_if;
    import gwma_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [OFS_W-1:0]   mean_offset_x;
    logic signed [OFS_W-1:0]   mean_offset_y;
    logic signed [POS_W-1:0]   mean_position_x;
    logic signed [POS_W-1:0]   mean_position_y;
    logic        [COLOR_W-1:0] out_color;
    logic                      out_found;

    modport source (
        output valid, mean_offset_x, mean_offset_y, mean_position_x, mean_position_y,
               out_color, out_found,
        input  ready
    );
    modport sink (
        input  valid, mean_offset_x, mean_offset_y, mean_position_x, mean_position_y,
               out_color, out_found,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/gated_weighted_moving_average_core.sv -----
// Gated weighted moving average over detection records.
//
// Input channel i_in (sink) takes one detection record per request; output
// channel o_out (source) gives one averaged record per input request, in order.
// Each record shifts into a five-entry window (oldest weight 1, newest weight 5).
// When all window colors match, the result is the weighted mean of each field,
// rounded to nearest with ties away from zero, plus that color and the OR of the
// found flags; otherwise the result is all zeros with found clear.
//
// Throughput: one record per cycle while the receiver takes results; the
// pipeline is window register, weighted sum register, reciprocal multiply
// register and output register.
// Reset clears the window to zero records and empties the pipeline, so the first
// four results average in zero records.
// When the receiver stalls, each stage holds until the one after it frees up;
// the input stays ready until all four stages are full.
//
// depends on gwma_pkg, gwma_if, gwma_lane and the assertion macro header
`default_nettype none

`include "gated_weighted_moving_average_core_assert.svh"

module gated_weighted_moving_average_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gwma_in_if.sink   i_in,
    gwma_out_if.source o_out
);
    import gwma_pkg::*;

    // window storage, index 0 oldest
    logic signed [OFS_W-1:0]   r_ofs_x_win [WIN_DEPTH];
    logic signed [OFS_W-1:0]   r_ofs_y_win [WIN_DEPTH];
    logic signed [POS_W-1:0]   r_pos_x_win [WIN_DEPTH];
    logic signed [POS_W-1:0]   r_pos_y_win [WIN_DEPTH];
    logic        [COLOR_W-1:0] r_color_win [WIN_DEPTH];
    logic        [WIN_DEPTH-1:0] r_found_win;

    // stage valid flags: window, sum, divide, output
    logic r_v0, r_v1, r_v2, r_v3;
    logic rdy0, rdy1, rdy2, rdy3;
    logic in_acc;
    logic en_out;
    t_stage_en stage_en;

    // side data that follows the lanes
    logic                n_same;
    logic                n_any;
    logic                r_same1, r_same2;
    logic                r_any1, r_any2;
    logic [COLOR_W-1:0]  r_color1, r_color2;

    t_lane_win  lane_win [4];
    t_lane_word lane_mean [4];

    // output register
    logic signed [OFS_W-1:0]   r_out_ofs_x;
    logic signed [OFS_W-1:0]   r_out_ofs_y;
    logic signed [POS_W-1:0]   r_out_pos_x;
    logic signed [POS_W-1:0]   r_out_pos_y;
    logic        [COLOR_W-1:0] r_out_color;
    logic                      r_out_found;

    // ready chain, a stage may load when it is empty or moving on
    always_comb begin
        rdy3   = !r_v3 || o_out.ready;
        rdy2   = !r_v2 || rdy3;
        rdy1   = !r_v1 || rdy2;
        rdy0   = !r_v0 || rdy1;
        in_acc = i_in.valid && rdy0;
        stage_en.en_sum = r_v0 && rdy1;
        stage_en.en_div = r_v1 && rdy2;
        en_out = r_v2 && rdy3;
    end

    assign i_in.ready = rdy0;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= in_acc;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // window shift on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_ofs_x_win[k] <= '0;
                r_ofs_y_win[k] <= '0;
                r_pos_x_win[k] <= '0;
                r_pos_y_win[k] <= '0;
                r_color_win[k] <= '0;
            end
            r_found_win <= '0;
        end else if (in_acc) begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                r_ofs_x_win[k] <= r_ofs_x_win[k+1];
                r_ofs_y_win[k] <= r_ofs_y_win[k+1];
                r_pos_x_win[k] <= r_pos_x_win[k+1];
                r_pos_y_win[k] <= r_pos_y_win[k+1];
                r_color_win[k] <= r_color_win[k+1];
            end
            r_ofs_x_win[WIN_DEPTH-1] <= i_in.offset_x;
            r_ofs_y_win[WIN_DEPTH-1] <= i_in.offset_y;
            r_pos_x_win[WIN_DEPTH-1] <= i_in.position_x;
            r_pos_y_win[WIN_DEPTH-1] <= i_in.position_y;
            r_color_win[WIN_DEPTH-1] <= i_in.color_class;
            r_found_win <= {i_in.detected, r_found_win[WIN_DEPTH-1:1]};
        end
    end

    // widen the four numeric fields to lane width
    always_comb begin
        for (int k = 0; k < WIN_DEPTH; k++) begin
            lane_win[0][k] = LANE_W'(r_ofs_x_win[k]);
            lane_win[1][k] = LANE_W'(r_ofs_y_win[k]);
            lane_win[2][k] = LANE_W'(r_pos_x_win[k]);
            lane_win[3][k] = LANE_W'(r_pos_y_win[k]);
        end
    end

    // color agreement and found flag over the window
    always_comb begin
        n_same = 1'b1;
        for (int k = 1; k < WIN_DEPTH; k++) begin
            if (r_color_win[k] != r_color_win[0]) n_same = 1'b0;
        end
        n_any = |r_found_win;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en.en_sum) begin
            r_same1  <= n_same;
            r_any1   <= n_any;
            r_color1 <= r_color_win[0];
        end
        if (stage_en.en_div) begin
            r_same2  <= r_same1;
            r_any2   <= r_any1;
            r_color2 <= r_color1;
        end
    end

    // four arithmetic lanes
    for (genvar g = 0; g < 4; g++) begin : g_lane
        gwma_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (stage_en),
            .i_win  (lane_win[g]),
            .o_mean (lane_mean[g])
        );
    end

    // result register, zero record when colors differ
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            if (r_same2) begin
                r_out_ofs_x <= OFS_W'(lane_mean[0]);
                r_out_ofs_y <= OFS_W'(lane_mean[1]);
                r_out_pos_x <= POS_W'(lane_mean[2]);
                r_out_pos_y <= POS_W'(lane_mean[3]);
                r_out_color <= r_color2;
                r_out_found <= r_any2;
            end else begin
                r_out_ofs_x <= '0;
                r_out_ofs_y <= '0;
                r_out_pos_x <= '0;
                r_out_pos_y <= '0;
                r_out_color <= '0;
                r_out_found <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_v3;
    assign o_out.mean_offset_x   = r_out_ofs_x;
    assign o_out.mean_offset_y   = r_out_ofs_y;
    assign o_out.mean_position_x = r_out_pos_x;
    assign o_out.mean_position_y = r_out_pos_y;
    assign o_out.out_color       = r_out_color;
    assign o_out.out_found       = r_out_found;

    // checks
    `GWMA_ASSERT_NEXT(a_accept_fills_window, i_clk, i_rst_n, in_acc, r_v0, "window not marked full")
    `GWMA_ASSERT_NEXT(a_sum_stage_loads, i_clk, i_rst_n, stage_en.en_sum, r_v1, "sum stage lost a request")
    `GWMA_ASSERT_IMPLY(a_block_only_when_full, i_clk, i_rst_n, !i_in.ready, r_v0 && r_v1 && r_v2 && r_v3, "input blocked with a free stage")
    `GWMA_ASSERT_NEXT(a_mismatch_gives_zero, i_clk, i_rst_n, en_out && !r_same2, !r_out_found && r_out_color == '0 && r_out_ofs_x == '0 && r_out_pos_y == '0, "color mismatch result not zero")

endmodule

`default_nettype wire

// ----- hdl/gwma_lane.sv -----
// one arithmetic lane: weighted sum, reciprocal multiply, rounding correction
// depends on gwma_pkg; stage enables come from the core's pipeline control
`default_nettype none

module gwma_lane (
    input  wire logic                i_clk,
    input  wire gwma_pkg::t_stage_en i_en,
    input  wire gwma_pkg::t_lane_win i_win,
    output gwma_pkg::t_lane_word     o_mean
);
    import gwma_pkg::*;

    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     n_neg;
    logic        [SUM_W-1:0]  n_mag;
    logic        [NUM_W-1:0]  n_num;
    logic                     r_neg;
    logic        [NUM_W-1:0]  r_num;
    logic        [PROD_W-1:0] r_prod;
    logic        [REC_W-1:0]  q_est;
    logic        [NUM_W-1:0]  rem;
    logic        [REC_W-1:0]  q_fix;

    // weighted sum over the window, constant weights
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < WIN_DEPTH; k++) begin
            n_sum = n_sum + SUM_W'(i_win[k]) * $signed(SUM_W'(k + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_sum) begin
            r_sum <= n_sum;
        end
    end

    // magnitude and rounding numerator 2*|sum| + total
    always_comb begin
        n_neg = r_sum[SUM_W-1];
        n_mag = n_neg ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        n_num = {n_mag, 1'b0} + NUM_W'(WT_SUM);
    end

    // quotient estimate by reciprocal multiply, low by at most one
    always_ff @(posedge i_clk) begin
        if (i_en.en_div) begin
            r_neg  <= n_neg;
            r_num  <= n_num;
            r_prod <= PROD_W'(n_num) * PROD_W'(REC);
        end
    end

    // correct the estimate and restore the sign
    always_comb begin
        q_est  = r_prod[PROD_W-1:NUM_W];
        rem    = r_num - NUM_W'(NUM_W'(q_est) * NUM_W'(WT_DIV));
        q_fix  = (rem >= NUM_W'(WT_DIV)) ? q_est + REC_W'(1) : q_est;
        o_mean = r_neg ? t_lane_word'(-LANE_W'(q_fix)) : t_lane_word'(LANE_W'(q_fix));
    end

endmodule

`default_nettype wire
